>>> hdl/first_fit_heap_allocator_core_defines.svh
// assertion helpers shared by the allocator modules
`ifndef FIRST_FIT_HEAP_ALLOCATOR_CORE_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define FFA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define FFA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/ffa_pkg.sv
package ffa_pkg;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NOFIT   = 3'd1,
        ST_BADFREE = 3'd2,
        ST_FULL    = 3'd3,
        ST_ZERO    = 3'd4
    } ffa_status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_F_RD,
        S_F_CHK,
        S_C_RD,
        S_C_GET,
        S_C_NXT,
        S_C_END,
        S_S_RD,
        S_S_WR,
        S_S_INS,
        S_S_TAKE,
        S_DONE
    } ffa_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_F_RD,
        OP_F_CHK,
        OP_C_RD,
        OP_C_GET,
        OP_C_NXT,
        OP_C_END,
        OP_S_RD,
        OP_S_WR,
        OP_S_INS,
        OP_S_TAKE,
        OP_EMIT
    } ffa_op_t;

    typedef struct packed {
        ffa_op_t op;
    } ffa_cmd_t;

    typedef struct packed {
        logic load_free;
        logic more;
        logic hit;
        logic pair;
        logic split;
        logic shift;
        logic s_more;
    } ffa_stat_t;

endpackage

>>> hdl/ffa_cfg_if.sv
interface ffa_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] heap_base;

    modport source (output valid, heap_base, input ready);
    modport sink (input valid, heap_base, output ready);
endinterface

>>> hdl/ffa_req_if.sv
interface ffa_req_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [16:0] request_size;
    logic [31:0] free_address;

    modport source (output valid, mode, request_size, free_address, input ready);
    modport sink (input valid, mode, request_size, free_address, output ready);
endinterface

>>> hdl/ffa_rsp_if.sv
interface ffa_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] payload_address;
    logic [2:0]  status;

    modport source (output valid, payload_address, status, input ready);
    modport sink (input valid, payload_address, status, output ready);
endinterface

>>> hdl/first_fit_heap_allocator_core.sv
// first-fit heap allocator over an address-ordered block table
// channels: cfg writes heap_base (always ready); req carries mode, request_size
// and free_address; rsp returns payload_address and status, one per transaction
// a transaction is taken only while the core is idle; the result sits in an
// output register, so the next request is taken while that result still waits
// free: reads and checks each table entry in turn until the matching start
// allocate: one merge pass over the entries (read, then successor read when a
// pair can merge), then for a split each entry above the fit moves up one slot
// (read, then write); last the free remainder is inserted and the fit is taken
// the block table ram takes one read and one write per cycle
// reset: table holds one free block spanning the heap, heap_base is zero,
// no result is pending; no clearing pass is needed
// a stalled receiver holds the result; the core finishes its current work
// and then waits in its done state until the output register is free
module first_fit_heap_allocator_core
    import ffa_pkg::*;
#(
    parameter int HEAP_BYTES   = 65536,
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 9
) (
    input logic        clk,
    input logic        rst_n,
    ffa_cfg_if.sink    cfg,
    ffa_req_if.sink    req,
    ffa_rsp_if.source  rsp
);
    ffa_cmd_t  cmd;
    ffa_stat_t stat;

    // config writes land at once
    assign cfg.ready = 1'b1;

    // sequencer: walks free probe, merge, search, shift and insert steps
    ffa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath: block table ram, walk pointers, fit capture, result registers
    ffa_dp #(
        .HEAP_BYTES   (HEAP_BYTES),
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg.valid),
        .cfg_base   (cfg.heap_base),
        .req_mode   (req.mode),
        .req_size   (req.request_size),
        .req_addr   (req.free_address),
        .cmd        (cmd),
        .stat       (stat),
        .rsp_addr   (rsp.payload_address),
        .rsp_status (rsp.status)
    );
endmodule

>>> hdl/ffa_ram.sv
module ffa_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

>>> hdl/ffa_ctrl.sv
`include "first_fit_heap_allocator_core_defines.svh"

module ffa_ctrl
    import ffa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    input  ffa_stat_t stat,
    output ffa_cmd_t  cmd
);
    ffa_state_t state_reg, state_next;
    logic       rsp_valid_reg, rsp_valid_next;
    logic       emit;

    assign emit = (state_reg == S_DONE) && (!rsp_valid_reg || rsp_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (req_valid) state_next = stat.load_free ? S_F_RD : S_C_RD;
            S_F_RD:   state_next = S_F_CHK;
            S_F_CHK:  state_next = (!stat.hit && stat.more) ? S_F_RD : S_DONE;
            S_C_RD:   state_next = S_C_GET;
            S_C_GET:  state_next = stat.pair ? S_C_NXT : (stat.more ? S_C_RD : S_C_END);
            S_C_NXT:  state_next = stat.more ? S_C_RD : S_C_END;
            S_C_END:  state_next = !stat.split ? S_DONE : (stat.shift ? S_S_RD : S_S_INS);
            S_S_RD:   state_next = S_S_WR;
            S_S_WR:   state_next = stat.s_more ? S_S_RD : S_S_INS;
            S_S_INS:  state_next = S_S_TAKE;
            S_S_TAKE: state_next = S_DONE;
            S_DONE:   if (emit) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op = OP_NONE;
        unique case (state_reg)
            S_IDLE:   cmd.op = req_valid ? OP_LOAD : OP_NONE;
            S_F_RD:   cmd.op = OP_F_RD;
            S_F_CHK:  cmd.op = OP_F_CHK;
            S_C_RD:   cmd.op = OP_C_RD;
            S_C_GET:  cmd.op = OP_C_GET;
            S_C_NXT:  cmd.op = OP_C_NXT;
            S_C_END:  cmd.op = OP_C_END;
            S_S_RD:   cmd.op = OP_S_RD;
            S_S_WR:   cmd.op = OP_S_WR;
            S_S_INS:  cmd.op = OP_S_INS;
            S_S_TAKE: cmd.op = OP_S_TAKE;
            S_DONE:   cmd.op = emit ? OP_EMIT : OP_NONE;
            default:  cmd.op = OP_NONE;
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (emit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    `FFA_ASSERT_NEXT(a_accept_leaves_idle, req_valid && req_ready, state_reg != S_IDLE,
        "accepted transaction did not start work")
    `FFA_ASSERT_NEXT(a_done_delivers, emit, rsp_valid && (state_reg == S_IDLE),
        "finished result was not posted")
endmodule

>>> hdl/ffa_dp.sv
`include "first_fit_heap_allocator_core_defines.svh"

module ffa_dp
    import ffa_pkg::*;
#(
    parameter int HEAP_BYTES   = 65536,
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 9
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic [31:0] cfg_base,
    input  logic        req_mode,
    input  logic [16:0] req_size,
    input  logic [31:0] req_addr,
    input  ffa_cmd_t    cmd,
    output ffa_stat_t   stat,
    output logic [31:0] rsp_addr,
    output logic [2:0]  rsp_status
);
    localparam int SW = $clog2(HEAP_BYTES);
    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int EW = 2 * SW + 1;
    localparam logic [SW-1:0] HDR      = SW'(HEADER_BYTES);
    localparam logic [SW-1:0] RST_SIZE = SW'(HEAP_BYTES - HEADER_BYTES);
    localparam logic [17:0]   HDR1     = 18'(HEADER_BYTES + 1);
    localparam logic [CW-1:0] MAXC     = CW'(MAX_BLOCKS);

    typedef struct packed {
        logic          free;
        logic [SW-1:0] start;
        logic [SW-1:0] size;
    } ent_t;

    localparam ent_t RST_ENT = '{free: 1'b1, start: '0, size: RST_SIZE};

    logic [31:0]   base_reg, base_next;
    logic [16:0]   req_reg, req_next;
    logic [31:0]   off_reg, off_next;
    logic [CW-1:0] r_reg, r_next, w_reg, w_next, cnt_reg, cnt_next;
    ent_t          cur_reg, cur_next, fit_reg, fit_next;
    logic [IW-1:0] fidx_reg, fidx_next;
    logic          found_reg, found_next, exact_reg, exact_next;
    logic [31:0]   res_addr_reg, res_addr_next, rsp_addr_reg, rsp_addr_next;
    ffa_status_t   res_st_reg, res_st_next, rsp_st_reg, rsp_st_next;
    logic          e0_reg, e0_next, rd_zero_reg;

    logic          ram_we;
    logic [IW-1:0] ram_waddr, ram_raddr;
    logic [EW-1:0] ram_wdata, ram_rdata;

    ent_t          rd_ent, em_ent, mrg_ent;
    logic          em_en;
    logic [CW-1:0] r_inc1, r_inc2, r_dec, fit1;
    logic [17:0]   em_size, req18;
    logic          em_eq, em_big;
    logic [31:0]   payload;

    ffa_ram #(.WIDTH(EW), .DEPTH(MAX_BLOCKS)) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // entry 0 reads as the whole free heap until first written
    assign rd_ent  = (rd_zero_reg && e0_reg) ? RST_ENT : ent_t'(ram_rdata);
    assign r_inc1  = r_reg + CW'(1);
    assign r_inc2  = r_reg + CW'(2);
    assign r_dec   = r_reg - CW'(1);
    assign fit1    = CW'(fidx_reg) + CW'(1);
    assign req18   = 18'(req_reg);
    assign em_size = 18'(em_ent.size);
    assign em_eq   = (em_size == req18);
    assign em_big  = (em_size >= req18 + HDR1);
    assign payload = base_reg + 32'(fit_reg.start) + 32'(HEADER_BYTES);

    always_comb
    begin
        mrg_ent       = cur_reg;
        mrg_ent.size  = cur_reg.size + HDR + rd_ent.size;
        base_next     = cfg_valid ? cfg_base : base_reg;
        req_next      = req_reg;
        off_next      = off_reg;
        r_next        = r_reg;
        w_next        = w_reg;
        cnt_next      = cnt_reg;
        cur_next      = cur_reg;
        fit_next      = fit_reg;
        fidx_next     = fidx_reg;
        found_next    = found_reg;
        exact_next    = exact_reg;
        res_addr_next = res_addr_reg;
        res_st_next   = res_st_reg;
        rsp_addr_next = rsp_addr_reg;
        rsp_st_next   = rsp_st_reg;
        ram_we        = 1'b0;
        ram_waddr     = w_reg[IW-1:0];
        ram_wdata     = rd_ent;
        ram_raddr     = r_reg[IW-1:0];
        em_en         = 1'b0;
        em_ent        = rd_ent;
        stat          = '0;
        stat.load_free = req_mode;

        unique case (cmd.op)
            OP_LOAD:
            begin
                req_next   = req_size;
                off_next   = req_addr - base_reg - 32'(HEADER_BYTES);
                r_next     = '0;
                w_next     = '0;
                found_next = 1'b0;
            end
            OP_F_CHK:
            begin
                stat.hit = (off_reg == 32'(rd_ent.start));
                res_addr_next = '0;
                if (stat.hit)
                begin
                    res_st_next = rd_ent.free ? ST_BADFREE : ST_OK;
                    ram_we      = !rd_ent.free;
                    ram_waddr   = r_reg[IW-1:0];
                    ram_wdata   = {1'b1, rd_ent.start, rd_ent.size};
                end
                else
                begin
                    r_next      = r_inc1;
                    res_st_next = ST_BADFREE;
                end
            end
            OP_C_GET:
            begin
                cur_next  = rd_ent;
                stat.pair = rd_ent.free && (r_inc1 < cnt_reg);
                if (stat.pair)
                begin
                    ram_raddr = r_inc1[IW-1:0];
                end
                else
                begin
                    em_en  = 1'b1;
                    em_ent = rd_ent;
                    r_next = r_inc1;
                end
            end
            OP_C_NXT:
            begin
                em_en = 1'b1;
                if (rd_ent.free)
                begin
                    em_ent = mrg_ent;
                    r_next = r_inc2;
                end
                else
                begin
                    em_ent = cur_reg;
                    r_next = r_inc1;
                end
            end
            OP_C_END:
            begin
                cnt_next      = w_reg;
                res_addr_next = '0;
                if (req_reg == '0)
                begin
                    res_st_next = ST_ZERO;
                end
                else if (!found_reg)
                begin
                    res_st_next = ST_NOFIT;
                end
                else if (exact_reg)
                begin
                    ram_we        = 1'b1;
                    ram_waddr     = fidx_reg;
                    ram_wdata     = {1'b0, fit_reg.start, fit_reg.size};
                    res_st_next   = ST_OK;
                    res_addr_next = payload;
                end
                else if (w_reg >= MAXC)
                begin
                    res_st_next = ST_FULL;
                end
                else
                begin
                    stat.split = 1'b1;
                    stat.shift = (w_reg > fit1);
                    r_next     = w_reg;
                end
            end
            OP_S_RD:
            begin
                ram_raddr = r_dec[IW-1:0];
            end
            OP_S_WR:
            begin
                ram_we      = 1'b1;
                ram_waddr   = r_reg[IW-1:0];
                ram_wdata   = rd_ent;
                r_next      = r_dec;
                stat.s_more = (r_dec > fit1);
            end
            OP_S_INS:
            begin
                ram_we    = 1'b1;
                ram_waddr = fit1[IW-1:0];
                ram_wdata = {1'b1, fit_reg.start + HDR + req_reg[SW-1:0],
                             fit_reg.size - req_reg[SW-1:0] - HDR};
            end
            OP_S_TAKE:
            begin
                ram_we        = 1'b1;
                ram_waddr     = fidx_reg;
                ram_wdata     = {1'b0, fit_reg.start, req_reg[SW-1:0]};
                cnt_next      = cnt_reg + CW'(1);
                res_st_next   = ST_OK;
                res_addr_next = payload;
            end
            OP_EMIT:
            begin
                rsp_addr_next = res_addr_reg;
                rsp_st_next   = res_st_reg;
            end
            default:
            begin
            end
        endcase

        // compaction write during the merge pass, with first-fit capture
        if (em_en)
        begin
            ram_we    = 1'b1;
            ram_waddr = w_reg[IW-1:0];
            ram_wdata = em_ent;
            w_next    = w_reg + CW'(1);
            if (!found_reg && (req_reg != '0) && em_ent.free && (em_eq || em_big))
            begin
                found_next = 1'b1;
                exact_next = em_eq;
                fit_next   = em_ent;
                fidx_next  = w_reg[IW-1:0];
            end
        end

        stat.more = (r_next < cnt_reg);
        e0_next   = e0_reg && !(ram_we && (ram_waddr == '0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg     <= '0;
            cnt_reg      <= CW'(1);
            e0_reg       <= 1'b1;
            rd_zero_reg  <= 1'b0;
            r_reg        <= '0;
            w_reg        <= '0;
            found_reg    <= 1'b0;
            exact_reg    <= 1'b0;
            req_reg      <= '0;
            off_reg      <= '0;
            cur_reg      <= '0;
            fit_reg      <= '0;
            fidx_reg     <= '0;
            res_addr_reg <= '0;
            res_st_reg   <= ST_OK;
            rsp_addr_reg <= '0;
            rsp_st_reg   <= ST_OK;
        end
        else
        begin
            base_reg     <= base_next;
            cnt_reg      <= cnt_next;
            e0_reg       <= e0_next;
            rd_zero_reg  <= (ram_raddr == '0);
            r_reg        <= r_next;
            w_reg        <= w_next;
            found_reg    <= found_next;
            exact_reg    <= exact_next;
            req_reg      <= req_next;
            off_reg      <= off_next;
            cur_reg      <= cur_next;
            fit_reg      <= fit_next;
            fidx_reg     <= fidx_next;
            res_addr_reg <= res_addr_next;
            res_st_reg   <= res_st_next;
            rsp_addr_reg <= rsp_addr_next;
            rsp_st_reg   <= rsp_st_next;
        end
    end

    assign rsp_addr   = rsp_addr_reg;
    assign rsp_status = rsp_st_reg;

    `FFA_ASSERT_NOW(a_count_range, 1'b1, (cnt_reg != '0) && (cnt_reg <= MAXC),
        "block count out of range")
endmodule
